// ----- design/sac_pkg.sv -----
package sac_pkg;

    // Fraction bits of a time value; one whole frame is 2**TIME_FRAC_BITS.
    localparam int TIME_FRAC_BITS = 16;
    // Signed time width, wide enough for plus and minus the saturation bound.
    localparam int TW = TIME_FRAC_BITS + 3;
    // Quotient bits produced by the divider, one per pipeline stage.
    localparam int QB = TIME_FRAC_BITS + 1;
    // Signed width of every edge sum and distance.
    localparam int DW = 27;
    // Width of the displacement fields.
    localparam int VW = 23;
    // Width of the partial remainder: distance magnitude shifted by the time fraction.
    localparam int NW = DW + TIME_FRAC_BITS;
    // Width of the hit time field.
    localparam int HW = TIME_FRAC_BITS + 1;

    localparam logic signed [TW-1:0] T_ONE = TW'(64'd1 << TIME_FRAC_BITS);
    localparam logic signed [TW-1:0] T_SAT = T_ONE + TW'(1);

    typedef enum logic [2:0] {
        C_NONE    = 3'd0,
        C_PX      = 3'd1,
        C_NX      = 3'd2,
        C_PY      = 3'd3,
        C_NY      = 3'd4,
        C_OVERLAP = 3'd5
    } t_contact;

    // One classified box pair on its way from the front part to the back part.
    typedef struct packed {
        logic                 swept;
        logic                 overlap;
        logic signed [DW-1:0] dxe;
        logic signed [DW-1:0] dxx;
        logic signed [DW-1:0] dye;
        logic signed [DW-1:0] dyx;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
    } t_job;

endpackage

// ----- design/sac_front.sv -----
module sac_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [23:0]          i_obj_x,
    input  logic signed [23:0]          i_obj_y,
    input  logic        [21:0]          i_obj_w,
    input  logic        [21:0]          i_obj_h,
    input  logic signed [22:0]          i_obj_vx,
    input  logic signed [22:0]          i_obj_vy,
    input  logic signed [23:0]          i_oth_x,
    input  logic signed [23:0]          i_oth_y,
    input  logic        [21:0]          i_oth_w,
    input  logic        [21:0]          i_oth_h,
    output logic                        o_push,
    output sac_pkg::t_job               o_job,
    input  logic                        i_full
);

    localparam int DW = sac_pkg::DW;

    logic                 r_valid;
    sac_pkg::t_job        r_job;
    sac_pkg::t_job        n_job;
    logic                 hold;
    logic signed [DW-1:0] x, y, w, h, vx, vy, ox, oy, ow, oh;
    logic signed [DW-1:0] bx, by, bw, bh;

    always_comb begin
        x  = DW'(i_obj_x);
        y  = DW'(i_obj_y);
        w  = DW'($signed({1'b0, i_obj_w}));
        h  = DW'($signed({1'b0, i_obj_h}));
        vx = DW'(i_obj_vx);
        vy = DW'(i_obj_vy);
        ox = DW'(i_oth_x);
        oy = DW'(i_oth_y);
        ow = DW'($signed({1'b0, i_oth_w}));
        oh = DW'($signed({1'b0, i_oth_h}));
        // Box swept by the displacement.
        bx = (vx > 0) ? x : x + vx;
        by = (vy > 0) ? y : y + vy;
        bw = w + ((vx < 0) ? -vx : vx);
        bh = h + ((vy < 0) ? -vy : vy);
        n_job.swept   = (ox <= bx + bw) && (ox + ow >= bx)
                     && (by + bh >= oy) && (by <= oy + oh);
        n_job.overlap = (ox <= x + w) && (ox + ow >= x)
                     && (y + h >= oy) && (y <= oy + oh);
        if (vx > 0) begin
            n_job.dxe = ox - (x + w);
            n_job.dxx = (ox + ow) - x;
        end else begin
            n_job.dxe = (ox + ow) - x;
            n_job.dxx = ox - (x + w);
        end
        if (vy > 0) begin
            n_job.dye = oy - (y + h);
            n_job.dyx = (oy + oh) - y;
        end else begin
            n_job.dye = (oy + oh) - y;
            n_job.dyx = oy - (y + h);
        end
        n_job.vx = i_obj_vx;
        n_job.vy = i_obj_vy;
    end

    assign hold    = r_valid && i_full;
    assign o_stall = hold;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!hold) begin
            r_valid <= i_valid;
        end
        if (!hold && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- design/sac_queue.sv -----
module sac_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sac_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sac_pkg::t_job o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    sac_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into a full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from an empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + (AW+1)'(1)))
        else $error("queue count lost a push");

endmodule

// ----- design/sac_div.sv -----
module sac_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [sac_pkg::DW-1:0]    i_d,
    input  logic signed [sac_pkg::VW-1:0]    i_v,
    output logic signed [sac_pkg::TW-1:0]    o_q
);

    localparam int DW = sac_pkg::DW;
    localparam int VW = sac_pkg::VW;
    localparam int NW = sac_pkg::NW;
    localparam int QB = sac_pkg::QB;
    localparam int TW = sac_pkg::TW;

    logic [NW-1:0] r_r   [QB+1];
    logic [VW-1:0] r_dv  [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_sat [QB+1];

    logic [DW-1:0] mag_d;
    logic [VW-1:0] mag_v;
    logic [TW-1:0] mag_q;
    logic [TW-1:0] floor_q;

    assign mag_d = i_d[DW-1] ? DW'(-i_d) : DW'(i_d);
    assign mag_v = i_v[VW-1] ? VW'(-i_v) : VW'(i_v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= {mag_d, sac_pkg::TIME_FRAC_BITS'(0)};
            r_dv[0]  <= mag_v;
            r_q[0]   <= '0;
            r_neg[0] <= (i_d[DW-1] != i_v[VW-1]);
            // The quotient reaches two frames or more: it saturates anyway.
            r_sat[0] <= (mag_d >= (DW'(mag_v) << 1));
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [NW-1:0] sub;
        logic          ge;
        assign sub = NW'(r_dv[k-1]) << (QB - k);
        assign ge  = (r_r[k-1] >= sub);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k]   <= ge ? r_r[k-1] - sub : r_r[k-1];
                r_q[k]   <= r_q[k-1] | (QB'(ge) << (QB - k));
                r_dv[k]  <= r_dv[k-1];
                r_neg[k] <= r_neg[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    always_comb begin
        // Negative quotients round toward minus infinity, so their magnitude rounds up.
        floor_q = TW'(r_q[QB]) + ((r_neg[QB] && (r_r[QB] != '0)) ? TW'(1) : TW'(0));
        if (r_sat[QB] || (floor_q > TW'(sac_pkg::T_SAT))) begin
            mag_q = TW'(sac_pkg::T_SAT);
        end else begin
            mag_q = floor_q;
        end
        o_q = r_neg[QB] ? -$signed(mag_q) : $signed(mag_q);
    end

endmodule

// ----- design/sac_back.sv -----
module sac_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  sac_pkg::t_job                 i_job,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [2:0]                    o_contact,
    output logic [sac_pkg::HW-1:0]        o_hit_time,
    output logic signed [1:0]             o_normal_x,
    output logic signed [1:0]             o_normal_y
);

    localparam int QB = sac_pkg::QB;
    localparam int TW = sac_pkg::TW;
    localparam int HW = sac_pkg::HW;

    typedef struct packed {
        logic swept;
        logic overlap;
        logic vx_zero;
        logic vy_zero;
        logic dxe_neg;
        logic dye_neg;
    } t_side;

    logic  en;
    logic  r_sv [QB+1];
    t_side r_sd [QB+1];
    t_side side_in;

    logic signed [TW-1:0] q_xe, q_xx, q_ye, q_yx;
    logic signed [TW-1:0] txe, txx, tye, tyx, ent, ext;
    logic                 is_hit;

    sac_pkg::t_contact    n_contact;
    logic [HW-1:0]        n_hit;
    logic signed [1:0]    n_nx, n_ny;

    sac_pkg::t_contact    r_contact;
    logic [HW-1:0]        r_hit;
    logic signed [1:0]    r_nx, r_ny;
    logic                 r_ov;

    // The whole pipeline moves unless a finished word sits stalled at the output.
    assign en    = !r_ov || !i_stall;
    assign o_pop = en && i_q_valid;

    assign side_in = '{swept:   i_job.swept,
                       overlap: i_job.overlap,
                       vx_zero: (i_job.vx == '0),
                       vy_zero: (i_job.vy == '0),
                       dxe_neg: i_job.dxe[sac_pkg::DW-1],
                       dye_neg: i_job.dye[sac_pkg::DW-1]};

    sac_div u_div_xe (.i_clk(i_clk), .i_en(en), .i_d(i_job.dxe), .i_v(i_job.vx), .o_q(q_xe));
    sac_div u_div_xx (.i_clk(i_clk), .i_en(en), .i_d(i_job.dxx), .i_v(i_job.vx), .o_q(q_xx));
    sac_div u_div_ye (.i_clk(i_clk), .i_en(en), .i_d(i_job.dye), .i_v(i_job.vy), .o_q(q_ye));
    sac_div u_div_yx (.i_clk(i_clk), .i_en(en), .i_d(i_job.dyx), .i_v(i_job.vy), .o_q(q_yx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_q_valid;
        end
        if (en) begin
            r_sd[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (en) begin
                r_sv[k] <= r_sv[k-1];
            end
            if (en) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    always_comb begin
        txe = r_sd[QB].vx_zero ? -sac_pkg::T_SAT : q_xe;
        txx = r_sd[QB].vx_zero ?  sac_pkg::T_SAT : q_xx;
        tye = r_sd[QB].vy_zero ? -sac_pkg::T_SAT : q_ye;
        tyx = r_sd[QB].vy_zero ?  sac_pkg::T_SAT : q_yx;
        ent = (txe > tye) ? txe : tye;
        ext = (txx < tyx) ? txx : tyx;
        is_hit = !((ent > ext) || (txe < 0 && tye < 0)
                   || (txe > sac_pkg::T_ONE) || (tye > sac_pkg::T_ONE));
        n_contact = sac_pkg::C_NONE;
        n_hit     = HW'(sac_pkg::T_ONE);
        n_nx      = 2'sd0;
        n_ny      = 2'sd0;
        if (r_sd[QB].swept) begin
            if (is_hit && (ent < sac_pkg::T_ONE)) begin
                n_hit = HW'(ent);
                if (txe > tye) begin
                    n_nx      = r_sd[QB].dxe_neg ? 2'sd1 : -2'sd1;
                    n_contact = r_sd[QB].dxe_neg ? sac_pkg::C_PX : sac_pkg::C_NX;
                end else begin
                    n_ny      = r_sd[QB].dye_neg ? 2'sd1 : -2'sd1;
                    n_contact = r_sd[QB].dye_neg ? sac_pkg::C_PY : sac_pkg::C_NY;
                end
            end else if (r_sd[QB].overlap) begin
                n_contact = sac_pkg::C_OVERLAP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sv[QB];
        end
        if (en) begin
            r_contact <= n_contact;
            r_hit     <= n_hit;
            r_nx      <= n_nx;
            r_ny      <= n_ny;
        end
    end

    assign o_valid    = r_ov;
    assign o_contact  = r_contact;
    assign o_hit_time = r_hit;
    assign o_normal_x = r_nx;
    assign o_normal_y = r_ny;

endmodule

// ----- design/swept_aabb_collision.sv -----
// Swept box collision test for 2D: each word carries a moving box (left and bottom edge, size
// and displacement for this frame, Q16.8, signed but for the unsigned size) and a static box,
// and yields one result word with a contact code, the entry time as a Q0.16 fraction of the
// frame (65536 when there is no hit) and the contact normal. The block takes one word per
// clock while o_stall is low and returns one word per clock when the output is not stalled.
// From input acceptance to output valid a word passes the front register that classifies the
// pair and forms the edge distances, loaded at acceptance, then the four-entry queue, eighteen
// stages of the restoring dividers (an input stage, then one quotient bit per stage, four
// dividers side by side for the x and y entry and exit times), and the output register that
// resolves hit time, normal and contact code.
// The queue lets the front keep taking words after the output stalls, until the queue is full.
module swept_aabb_collision (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [23:0]          i_obj_x,
    input  logic signed [23:0]          i_obj_y,
    input  logic        [21:0]          i_obj_w,
    input  logic        [21:0]          i_obj_h,
    input  logic signed [22:0]          i_obj_vx,
    input  logic signed [22:0]          i_obj_vy,
    input  logic signed [23:0]          i_oth_x,
    input  logic signed [23:0]          i_oth_y,
    input  logic        [21:0]          i_oth_w,
    input  logic        [21:0]          i_oth_h,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_contact,
    output logic [sac_pkg::HW-1:0]      o_hit_time,
    output logic signed [1:0]           o_normal_x,
    output logic signed [1:0]           o_normal_y
);

    // Front to queue.
    logic          push;
    logic          full;
    sac_pkg::t_job front_job;

    // Queue to back.
    logic          pop;
    logic          q_valid;
    sac_pkg::t_job q_job;

    sac_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_obj_x  (i_obj_x),
        .i_obj_y  (i_obj_y),
        .i_obj_w  (i_obj_w),
        .i_obj_h  (i_obj_h),
        .i_obj_vx (i_obj_vx),
        .i_obj_vy (i_obj_vy),
        .i_oth_x  (i_oth_x),
        .i_oth_y  (i_oth_y),
        .i_oth_w  (i_oth_w),
        .i_oth_h  (i_oth_h),
        .o_push   (push),
        .o_job    (front_job),
        .i_full   (full)
    );

    sac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    sac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (q_job),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_contact  (o_contact),
        .o_hit_time (o_hit_time),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y)
    );

    // A word with no hit carries the "none" time and a zero normal.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_contact == sac_pkg::C_NONE || o_contact == sac_pkg::C_OVERLAP))
        |-> (o_hit_time == sac_pkg::HW'(sac_pkg::T_ONE) && o_normal_x == 2'sd0
             && o_normal_y == 2'sd0))
        else $error("non-hit word with time or normal");

    // An x contact has a normal along x only.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_contact == sac_pkg::C_PX || o_contact == sac_pkg::C_NX))
        |-> (o_normal_y == 2'sd0 && o_normal_x != 2'sd0))
        else $error("x contact with a bad normal");

    // A y contact happens before the end of the frame and has a zero x normal.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_contact == sac_pkg::C_PY || o_contact == sac_pkg::C_NY))
        |-> (o_hit_time < sac_pkg::HW'(sac_pkg::T_ONE) && o_normal_x == 2'sd0))
        else $error("y contact with a bad time or normal");

endmodule
